// ===== src/lfcs_pkg.sv =====
// Package for the line follower crossing sequencer.
// Holds codes, the configuration record, the maneuver tables and the drive
// scaling functions. No dependencies.
package lfcs_pkg;

  localparam int SpeedW  = 9;
  localparam int DriveW  = 10;
  localparam int FlagsW  = 5;
  localparam int ElapsW  = 16;
  localparam int DwellW  = 8;
  localparam int ChoiceW = 2;
  localparam int IdxW    = 2;
  localparam int PhaseW  = 2;
  localparam int StepW   = 2;

  localparam logic [IdxW-1:0] REG_BASE_LEFT  = 2'd0;
  localparam logic [IdxW-1:0] REG_BASE_RIGHT = 2'd1;
  localparam logic [IdxW-1:0] REG_TURN       = 2'd2;
  localparam logic [IdxW-1:0] REG_DWELL      = 2'd3;

  localparam logic [ChoiceW-1:0] TURN_RIGHT    = 2'd0;
  localparam logic [ChoiceW-1:0] TURN_LEFT     = 2'd1;
  localparam logic [ChoiceW-1:0] TURN_STRAIGHT = 2'd2;

  localparam logic [StepW-1:0] STEP_RIGHT    = 2'd0;
  localparam logic [StepW-1:0] STEP_LEFT     = 2'd1;
  localparam logic [StepW-1:0] STEP_STRAIGHT = 2'd2;

  localparam logic [PhaseW-1:0] PH_BEFORE = 2'd0;
  localparam logic [PhaseW-1:0] PH_CROSS1 = 2'd1;
  localparam logic [PhaseW-1:0] PH_CROSS2 = 2'd2;
  localparam logic [PhaseW-1:0] PH_CROSS3 = 2'd3;

  localparam logic [10:0] SCALE_LOW  = 11'd850;
  localparam logic [10:0] SCALE_HIGH = 11'd1188;

  localparam logic signed [SpeedW-1:0] RESET_SPEED = 9'sd100;
  localparam logic [DwellW-1:0]        RESET_DWELL = 8'd30;

  typedef struct packed {
    logic signed [SpeedW-1:0] base_left_speed;
    logic signed [SpeedW-1:0] base_right_speed;
    logic [ChoiceW-1:0]       turn_choice;
    logic [DwellW-1:0]        dwell_limit;
  } cfg_t;

  // Number of steps in the maneuver list for a turn choice.
  function automatic logic [IdxW:0] list_len(input logic [ChoiceW-1:0] choice);
    logic [IdxW:0] len;
    case (choice)
      TURN_RIGHT: len = 3'd1;
      TURN_LEFT:  len = 3'd3;
      default:    len = 3'd2;
    endcase
    return len;
  endfunction

  function automatic logic [StepW-1:0] step_of(input logic [ChoiceW-1:0] choice,
                                               input logic [StepW-1:0] idx);
    logic [StepW-1:0] s;
    s = STEP_STRAIGHT;
    case (choice)
      TURN_RIGHT: if (idx == 2'd0) s = STEP_RIGHT;
      TURN_LEFT:  if (idx == 2'd1) s = STEP_LEFT;
      default:    s = STEP_STRAIGHT;
    endcase
    return s;
  endfunction

  // v * num / 1024, truncated toward zero.
  function automatic logic signed [DriveW-1:0] scale(input logic signed [SpeedW-1:0] v,
                                                     input logic [10:0] num);
    logic signed [20:0] p;
    p = $signed({{12{v[SpeedW-1]}}, v}) * $signed({10'b0, num});
    if (p < 0) begin
      p = p + 21'sd1023;
    end
    return DriveW'(p >>> 10);
  endfunction

  // v / -2, truncated toward zero.
  function automatic logic signed [DriveW-1:0] half_neg(input logic signed [SpeedW-1:0] v);
    logic signed [SpeedW-1:0] h;
    h = (v + $signed({{(SpeedW-1){1'b0}}, v[SpeedW-1]})) >>> 1;
    return -(DriveW'(h));
  endfunction

endpackage

// ===== src/lfcs_tick_if.sv =====
// Input channel of the crossing sequencer: one sensor tick per transfer.
// Depends on lfcs_pkg for field widths.
interface lfcs_tick_if;
  logic                          valid;
  logic                          ready;
  logic [lfcs_pkg::FlagsW-1:0]   line_flags;
  logic                          centre_back;
  logic [lfcs_pkg::ElapsW-1:0]   elapsed;

  modport source (output valid, line_flags, centre_back, elapsed, input ready);
  modport sink   (input valid, line_flags, centre_back, elapsed, output ready);
endinterface

// ===== src/lfcs_result_if.sv =====
// Output channel of the crossing sequencer: one result per tick.
// Depends on lfcs_pkg for field widths.
interface lfcs_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [lfcs_pkg::DriveW-1:0]  left_drive;
  logic signed [lfcs_pkg::DriveW-1:0]  right_drive;
  logic                                drive_update;
  logic                                maneuver_done;
  logic [lfcs_pkg::PhaseW-1:0]         phase_now;

  modport source (output valid, left_drive, right_drive, drive_update, maneuver_done,
                  phase_now, input ready);
  modport sink   (input valid, left_drive, right_drive, drive_update, maneuver_done,
                  phase_now, output ready);
endinterface

// ===== src/lfcs_cfg_regs.sv =====
// Configuration registers of the crossing sequencer.
// Depends on lfcs_pkg for the register indexes and the cfg_t record.
module lfcs_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [lfcs_pkg::IdxW-1:0]     wr_index,
  input  logic [lfcs_pkg::SpeedW-1:0]   wr_data,
  output lfcs_pkg::cfg_t                cfg
);
  import lfcs_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_left_speed  <= RESET_SPEED;
      cfg.base_right_speed <= RESET_SPEED;
      cfg.turn_choice      <= TURN_STRAIGHT;
      cfg.dwell_limit      <= RESET_DWELL;
    end else if (wr_en) begin
      case (wr_index)
        REG_BASE_LEFT:  cfg.base_left_speed  <= $signed(wr_data);
        REG_BASE_RIGHT: cfg.base_right_speed <= $signed(wr_data);
        REG_TURN:       cfg.turn_choice      <= wr_data[ChoiceW-1:0];
        REG_DWELL:      cfg.dwell_limit      <= wr_data[DwellW-1:0];
        default: ;
      endcase
    end
  end
endmodule

// ===== src/lfcs_step.sv =====
// Sequencer state (phase, step index, dwell timer) and the per-tick logic.
// Depends on lfcs_pkg for codes, tables and scaling functions.
module lfcs_step (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                fire,
  input  lfcs_pkg::cfg_t                      cfg,
  input  logic [lfcs_pkg::FlagsW-1:0]         line_flags,
  input  logic                                centre_back,
  input  logic [lfcs_pkg::ElapsW-1:0]         elapsed,
  output logic signed [lfcs_pkg::DriveW-1:0]  left_drive,
  output logic signed [lfcs_pkg::DriveW-1:0]  right_drive,
  output logic                                drive_update,
  output logic                                maneuver_done,
  output logic [lfcs_pkg::PhaseW-1:0]         phase_now
);
  import lfcs_pkg::*;

  logic [PhaseW-1:0] phase, phase_next;
  logic [StepW-1:0]  step_index, step_index_next;
  logic [DwellW-1:0] dwell_time, dwell_time_next;

  logic [ElapsW:0]             dwell_sum;
  logic                        dwell_over;
  logic                        outer;
  logic [StepW-1:0]            step;
  logic                        steer_ok;
  logic signed [DriveW-1:0]    steer_l, steer_r, turn_l, turn_r, l, r;

  assign dwell_sum  = {1'b0, elapsed} + {{(ElapsW+1-DwellW){1'b0}}, dwell_time};
  assign dwell_over = dwell_sum > {{(ElapsW+1-DwellW){1'b0}}, cfg.dwell_limit};
  assign outer      = line_flags[0] | line_flags[4];
  assign step       = step_of(cfg.turn_choice, step_index);

  always_comb begin
    steer_ok = 1'b1;
    steer_l  = DriveW'(cfg.base_left_speed);
    steer_r  = DriveW'(cfg.base_right_speed);
    if (line_flags[2]) begin
      steer_l = DriveW'(cfg.base_left_speed);
      steer_r = DriveW'(cfg.base_right_speed);
    end else if (line_flags[1]) begin
      steer_l = scale(cfg.base_left_speed, SCALE_LOW);
      steer_r = scale(cfg.base_right_speed, SCALE_HIGH);
    end else if (line_flags[3]) begin
      steer_l = scale(cfg.base_left_speed, SCALE_HIGH);
      steer_r = scale(cfg.base_right_speed, SCALE_LOW);
    end else begin
      steer_ok = 1'b0;
    end
    // Anything but a left step in the turning phases steers as a right turn.
    if (step == STEP_LEFT) begin
      turn_l = half_neg(cfg.base_left_speed);
      turn_r = DriveW'(cfg.base_right_speed);
    end else begin
      turn_l = DriveW'(cfg.base_left_speed);
      turn_r = half_neg(cfg.base_right_speed);
    end
  end

  always_comb begin
    phase_next      = phase;
    step_index_next = step_index;
    dwell_time_next = dwell_time;
    drive_update    = 1'b0;
    maneuver_done   = 1'b0;
    l               = steer_l;
    r               = steer_r;
    if ({1'b0, step_index} >= list_len(cfg.turn_choice)) begin
      step_index_next = '0;
      maneuver_done   = 1'b1;
    end else begin
      case (phase)
        PH_BEFORE: begin
          if (!outer) begin
            dwell_time_next = '0;
            drive_update    = steer_ok;
          end else if (dwell_over) begin
            dwell_time_next = '0;
            phase_next      = PH_CROSS1;
          end else begin
            dwell_time_next = dwell_sum[DwellW-1:0];
          end
        end
        PH_CROSS1: begin
          if (outer) begin
            dwell_time_next = '0;
            drive_update    = steer_ok;
          end else if (dwell_over) begin
            dwell_time_next = '0;
            phase_next      = PH_CROSS2;
          end else begin
            dwell_time_next = dwell_sum[DwellW-1:0];
          end
        end
        PH_CROSS2: begin
          if (step == STEP_STRAIGHT) begin
            step_index_next = step_index + 2'd1;
            phase_next      = PH_BEFORE;
          end else begin
            drive_update = 1'b1;
            l            = turn_l;
            r            = turn_r;
            if (!centre_back) begin
              dwell_time_next = '0;
            end else if (dwell_over) begin
              dwell_time_next = '0;
              phase_next      = PH_CROSS3;
            end else begin
              dwell_time_next = dwell_sum[DwellW-1:0];
            end
          end
        end
        default: begin
          drive_update = 1'b1;
          l            = turn_l;
          r            = turn_r;
          if (!line_flags[2]) begin
            dwell_time_next = '0;
          end else if (dwell_over) begin
            dwell_time_next = '0;
            phase_next      = PH_BEFORE;
            step_index_next = step_index + 2'd1;
          end else begin
            dwell_time_next = dwell_sum[DwellW-1:0];
          end
        end
      endcase
    end
    left_drive  = drive_update ? l : '0;
    right_drive = drive_update ? r : '0;
    phase_now   = phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_BEFORE;
      step_index <= '0;
      dwell_time <= '0;
    end else if (fire) begin
      phase      <= phase_next;
      step_index <= step_index_next;
      dwell_time <= dwell_time_next;
    end
  end
endmodule

// ===== src/line_follower_crossing_sequencer.sv =====
// Top level of the line follower crossing sequencer: input register, step
// logic and result register. Depends on lfcs_pkg, lfcs_tick_if,
// lfcs_result_if, lfcs_cfg_regs and lfcs_step.
//
//   channel  direction  transfer carries
//   tick     in         line_flags, centre_back, elapsed
//   result   out        left_drive, right_drive, drive_update, maneuver_done,
//                       phase_now
//   wr_*     in         wr_en, wr_index, wr_data (register write, no wait)
//
// One tick per cycle sustained while the result channel does not stall; a
// result is presented once its tick has passed through the input register
// and then the result register. The sequencer state advances when a tick
// moves from the input register to the result register, so results stay in
// tick order under any stall. A stalled result holds the result register; a
// new tick is still taken into the input register while it is empty. Reset
// clears the valid flags and the sequencer state and loads the register
// defaults.
module line_follower_crossing_sequencer (
  input  logic                        clk,
  input  logic                        rst,
  lfcs_tick_if.sink                   tick,
  lfcs_result_if.source               result,
  input  logic                        wr_en,
  input  logic [lfcs_pkg::IdxW-1:0]   wr_index,
  input  logic [lfcs_pkg::SpeedW-1:0] wr_data
);
  import lfcs_pkg::*;

  cfg_t cfg;

  logic              in_valid;
  logic [FlagsW-1:0] in_flags;
  logic              in_back;
  logic [ElapsW-1:0] in_elapsed;

  logic                     out_free;
  logic                     fire;
  logic signed [DriveW-1:0] left_drive, right_drive;
  logic                     drive_update, maneuver_done;
  logic [PhaseW-1:0]        phase_now;

  assign out_free   = !result.valid || result.ready;
  assign fire       = in_valid && out_free;
  assign tick.ready = !in_valid || out_free;

  lfcs_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  lfcs_step u_step (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .cfg           (cfg),
    .line_flags    (in_flags),
    .centre_back   (in_back),
    .elapsed       (in_elapsed),
    .left_drive    (left_drive),
    .right_drive   (right_drive),
    .drive_update  (drive_update),
    .maneuver_done (maneuver_done),
    .phase_now     (phase_now)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (tick.ready) begin
      in_valid <= tick.valid;
    end
    if (tick.ready && tick.valid) begin
      in_flags   <= tick.line_flags;
      in_back    <= tick.centre_back;
      in_elapsed <= tick.elapsed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_free) begin
      result.valid <= in_valid;
    end
    if (fire) begin
      result.left_drive    <= left_drive;
      result.right_drive   <= right_drive;
      result.drive_update  <= drive_update;
      result.maneuver_done <= maneuver_done;
      result.phase_now     <= phase_now;
    end
  end
endmodule
